[hdl/bpd_pkg.sv]
// Shared types and constants for the byte-pair decompressor.
package bpd_pkg;

  localparam int unsigned AlphabetSize = 256;
  localparam int unsigned StackDepth   = 256;
  localparam int unsigned SymW         = 8;
  localparam int unsigned SymAw        = $clog2(AlphabetSize);
  localparam int unsigned StkAw        = $clog2(StackDepth);
  localparam int unsigned StkCntW      = StkAw + 1;
  localparam logic [StkCntW-1:0] StkLimit = StkCntW'(StackDepth - 2);

  localparam logic [2:0] StMore     = 3'd0;
  localparam logic [2:0] StDrain    = 3'd1;
  localparam logic [2:0] StDone     = 3'd2;
  localparam logic [2:0] StFormat   = 3'd3;
  localparam logic [2:0] StOverflow = 3'd4;
  localparam logic [2:0] StStack    = 3'd5;
  localparam logic [2:0] StSize     = 3'd6;
  localparam logic [2:0] StProtocol = 3'd7;

  localparam logic ReqPush  = 1'b0;
  localparam logic ReqDrain = 1'b1;

  localparam logic [1:0] AddrExpectedSize = 2'd0;

  typedef enum logic [3:0] {
    PhCtrl, PhLeft, PhRight, PhLen0, PhLen1, PhLen2, PhLen3, PhData, PhDone, PhErr
  } phase_e;

  typedef enum logic [1:0] {
    PipeIdle, PipeRead, PipeFwdWait
  } pipe_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic [2:0] status;
    logic       expansion_pending;
  } out_word_t;

endpackage

[hdl/bpd_ram.sv]
// Generic single-port-write, single-read synchronous RAM with registered read.
module bpd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hdl/byte_pair_decompressor.sv]
// Byte-pair decompressor: parses per-block pair tables and expands packed symbols.
// Each accepted word produces exactly one result word. Table and length bytes
// finish in their accept cycle and leave the pipeline free for the next word. A
// data push addresses the left and right tables and samples the left-valid bit
// with the byte in its accept cycle, and the next cycle resolves the symbol from
// the registered RAM outputs. A drain reads the stack top in its accept cycle,
// addresses the tables with it in the PipeRead state and resolves in
// PipeFwdWait. A protocol error or a word after the stream has terminated is
// answered in its accept cycle. Left-table valid bits are flip-flops
// cleared together at each block start; the left and right tables are
// synchronous RAMs. A right entry is only read for a code whose left entry in
// the same block differs from the code, and the table format always writes that
// right entry before the block's data starts, so the right table needs no reset.
// The stack is a synchronous RAM indexed by the depth counter. A pair writes its
// right entry in the resolve cycle and its left entry in the cycle after; a drain
// taken in that later cycle gets the left entry forwarded instead of the stale
// RAM word. The output sits in a register, and a new word is accepted in the cycle
// its waiting result is taken; input is stalled whenever a word is in flight or
// the output holds a stalled result. expected_size is written through the APB port at address 0.
module byte_pair_decompressor
  import bpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [30:0] exp_size_q;
  assign pready = 1'b1;
  assign prdata = (paddr == AddrExpectedSize) ? {1'b0, exp_size_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_size_q <= '0;
    end else if (psel && penable && pwrite && (paddr == AddrExpectedSize)) begin
      exp_size_q <= pwdata[30:0];
    end
  end

  // Control state
  phase_e             phase_q, phase_d;
  logic [8:0]         code_q, code_d;
  logic [7:0]         run_q, run_d;
  logic [31:0]        blk_q, blk_d;
  logic [31:0]        prod_q, prod_d;
  logic               ended_q, ended_d;
  logic [2:0]         err_q, err_d;
  logic [StkCntW-1:0] depth_q, depth_d;
  logic [AlphabetSize-1:0] lw_q, lw_d;

  // Pipeline: stage A read of stack (drain), stage B read of tables
  pipe_e      pst_q, pst_d;
  logic [7:0] sym_q, sym_d;
  logic       fwd_q, fwd_d;   // stack top comes from the pending second write

  logic       ov_q, ov_d;
  out_word_t  ow_q, ow_d;

  logic in_acc, out_free;
  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = (pst_q != PipeIdle) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = ov_q;
  assign out_word_o  = ow_q;

  // RAMs
  logic       lt_we, rt_we, st_we;
  logic [7:0] lt_wa, rt_wa, lt_wd, rt_wd, lt_ra, rt_ra, lt_rd, rt_rd;
  logic [StkAw-1:0] st_wa, st_ra;
  logic [7:0] st_wd, st_rd;

  bpd_ram #(.Width(8), .Depth(AlphabetSize)) u_left (
    .clk_i, .we_i(lt_we), .waddr_i(lt_wa), .wdata_i(lt_wd), .raddr_i(lt_ra), .rdata_o(lt_rd));
  bpd_ram #(.Width(8), .Depth(AlphabetSize)) u_right (
    .clk_i, .we_i(rt_we), .waddr_i(rt_wa), .wdata_i(rt_wd), .raddr_i(rt_ra), .rdata_o(rt_rd));
  // Stack pushes two entries at once: even and odd halves would complicate
  // indexing, so the second entry (left) goes to a deferred write cycle.
  bpd_ram #(.Width(8), .Depth(StackDepth)) u_stack (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(st_wd), .raddr_i(st_ra), .rdata_o(st_rd));

  // pending second stack write
  logic             pw_q, pw_d;
  logic [StkAw-1:0] pwa_q, pwa_d;
  logic [7:0]       pwd_q, pwd_d;

  logic lw_b_q;   // valid bit sampled with the table read
  logic lw_b_d;

  always_comb begin
    logic [7:0] b, c, lf, rv, top;
    logic [9:0] cc;
    logic [2:0] st;
    logic       prot, emit, run_sym;
    logic [7:0] ob;
    phase_d = phase_q; code_d = code_q; run_d = run_q; blk_d = blk_q;
    prod_d = prod_q; ended_d = ended_q; err_d = err_q; depth_d = depth_q;
    lw_d = lw_q; pst_d = pst_q; sym_d = sym_q; fwd_d = 1'b0;
    pw_d = 1'b0; pwa_d = pwa_q; pwd_d = pwd_q;
    lw_b_d = lw_b_q;
    ov_d = ov_q && out_stall_i; ow_d = ow_q;
    lt_we = 1'b0; rt_we = 1'b0; lt_wa = '0; rt_wa = '0; lt_wd = '0; rt_wd = '0;
    lt_ra = sym_q; rt_ra = sym_q;
    st_we = pw_q; st_wa = pwa_q; st_wd = pwd_q;
    st_ra = StkAw'(depth_q - 1'b1);
    b = in_word_i.data_byte; c = code_q[7:0]; lf = '0; rv = '0; cc = '0; top = '0;
    prot = 1'b0; emit = 1'b0; run_sym = 1'b0; ob = '0; st = StMore;

    if (pst_q == PipeRead) begin
      // stack data ready (drain): address tables with it
      top = fwd_q ? pwd_q : st_rd;
      sym_d = top; lt_ra = top; rt_ra = top;
      lw_b_d = lw_q[top];
      pst_d = PipeFwdWait;
    end else if (pst_q == PipeFwdWait) begin
      run_sym = 1'b1;
    end

    if (run_sym) begin
      lf = lw_b_q ? lt_rd : sym_q;
      rv = rt_rd;
      if (lf == sym_q) begin
        if (prod_q >= {1'b0, exp_size_q}) begin
          phase_d = PhErr; err_d = StOverflow;
        end else begin
          emit = 1'b1; ob = sym_q; prod_d = prod_q + 32'd1;
        end
      end else if (depth_q > StkLimit) begin
        phase_d = PhErr; err_d = StStack;
      end else begin
        st_we = 1'b1; st_wa = StkAw'(depth_q); st_wd = rv;
        pw_d = 1'b1; pwa_d = StkAw'(depth_q + 1'b1); pwd_d = lf;
        depth_d = depth_q + StkCntW'(2);
      end
      if (phase_d != PhErr && depth_d == '0) begin
        if (blk_q == '0) begin
          if (ended_q) begin
            if (prod_d == {1'b0, exp_size_q}) phase_d = PhDone;
            else begin phase_d = PhErr; err_d = StSize; end
          end else begin
            lw_d = '0; code_d = '0; run_d = '0; phase_d = PhCtrl;
          end
        end else if (ended_q) begin
          phase_d = PhErr; err_d = StFormat;
        end
      end
      if (phase_d == PhErr) st = err_d;
      else if (phase_d == PhDone) st = StDone;
      else if (depth_d != '0) st = StDrain;
      else st = StMore;
      ov_d = 1'b1;
      ow_d = '{out_byte: ob, out_valid: emit, status: st,
               expansion_pending: depth_d != '0};
      pst_d = PipeIdle;
    end

    if (in_acc) begin
      st = StMore;
      if (phase_q == PhDone || phase_q == PhErr) begin
        st = (phase_q == PhDone) ? StDone : err_q;
        ov_d = 1'b1;
        ow_d = '{out_byte: 8'd0, out_valid: 1'b0, status: st, expansion_pending: depth_q != '0};
      end else if (in_word_i.req_type == ReqPush) begin
        if (phase_q == PhData && depth_q != '0) prot = 1'b1;
        else begin
          ended_d = in_word_i.last_byte;
          if (phase_q == PhData) begin
            blk_d = blk_q - 32'd1;
            sym_d = b; lt_ra = b; rt_ra = b;
            lw_b_d = lw_q[b];
            pst_d = PipeFwdWait;
          end else begin
            unique case (phase_q)
              PhCtrl: begin
                cc = {1'b0, code_q};
                if (b > 8'h7f) cc = cc + 10'(b - 8'h7f);
                code_d = cc[8:0];
                if (cc == 10'h100) phase_d = PhLen0;
                else if (cc > 10'h100) begin phase_d = PhErr; err_d = StFormat; end
                else begin run_d = (b > 8'h7f) ? 8'd0 : b; phase_d = PhLeft; end
              end
              PhLeft, PhRight: begin
                if (phase_q == PhLeft) begin
                  lt_we = 1'b1; lt_wa = c; lt_wd = b; lw_d[c] = 1'b1;
                end else begin
                  rt_we = 1'b1; rt_wa = c; rt_wd = b;
                end
                if (phase_q == PhLeft && b != c) phase_d = PhRight;
                else begin
                  code_d = code_q + 9'd1;
                  if (run_q == '0) phase_d = (code_d == 9'h100) ? PhLen0 : PhCtrl;
                  else begin
                    run_d = run_q - 8'd1;
                    if (code_d[8]) begin phase_d = PhErr; err_d = StFormat; end
                    else phase_d = PhLeft;
                  end
                end
              end
              PhLen0: begin blk_d = {24'd0, b}; phase_d = PhLen1; end
              PhLen1: begin blk_d[15:8] = b; phase_d = PhLen2; end
              PhLen2: begin blk_d[23:16] = b; phase_d = PhLen3; end
              PhLen3: begin
                blk_d[31:24] = b; phase_d = PhData;
                if (blk_d == '0) begin
                  if (in_word_i.last_byte) begin
                    if (prod_q == {1'b0, exp_size_q}) phase_d = PhDone;
                    else begin phase_d = PhErr; err_d = StSize; end
                  end else begin
                    lw_d = '0; code_d = '0; run_d = '0; phase_d = PhCtrl;
                  end
                end
              end
              default: ;
            endcase
            if (in_word_i.last_byte && phase_d != PhDone && phase_d != PhErr) begin
              phase_d = PhErr; err_d = StFormat;
            end
          end
        end
      end else begin
        if (depth_q == '0) prot = 1'b1;
        else begin
          depth_d = depth_q - 1'b1;
          st_ra = StkAw'(depth_q - 1'b1);
          // left entry of the last pair is still on its way into the RAM
          fwd_d = pw_q && (pwa_q == StkAw'(depth_q - 1'b1));
          pst_d = PipeRead;
        end
      end
      if (pst_d == PipeIdle && !(phase_q == PhDone || phase_q == PhErr)) begin
        if (prot) st = StProtocol;
        else if (phase_d == PhErr) st = err_d;
        else if (phase_d == PhDone) st = StDone;
        else if (depth_d != '0) st = StDrain;
        else st = StMore;
        ov_d = 1'b1;
        ow_d = '{out_byte: 8'd0, out_valid: 1'b0, status: st,
                 expansion_pending: depth_d != '0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhCtrl; code_q <= '0; run_q <= '0; blk_q <= '0; prod_q <= '0;
      ended_q <= 1'b0; err_q <= '0; depth_q <= '0; lw_q <= '0;
      pst_q <= PipeIdle; fwd_q <= 1'b0; pw_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      phase_q <= phase_d; code_q <= code_d; run_q <= run_d; blk_q <= blk_d;
      prod_q <= prod_d; ended_q <= ended_d; err_q <= err_d; depth_q <= depth_d;
      lw_q <= lw_d; pst_q <= pst_d; fwd_q <= fwd_d;
      pw_q <= pw_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d; pwa_q <= pwa_d; pwd_q <= pwd_d;
    lw_b_q <= lw_b_d; ow_q <= ow_d;
  end

  // Assertions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pst_q != PipeIdle) |-> in_stall_o) else $error("accepted during expansion");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (depth_q > StkCntW'(StackDepth)) == 1'b0) else $error("stack depth overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ow_q.out_valid) |-> (ow_q.status != StProtocol)) else $error("emit on protocol");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pw_q |-> $past(pst_q == PipeFwdWait)) else $error("stray second stack write");

endmodule

[test/bpd_checker.sv]
// Checker for the byte-pair decompressor: predicts each result word and compares.
`timescale 1ns / 1ps
module bpd_checker
  import bpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_word_t    in_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_word_t   out_word_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [1:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  input  logic        end_i,
  output int          fail_count_o
);

  // predictor state
  logic [7:0]  left_map [AlphabetSize];
  logic        left_set [AlphabetSize];
  logic [7:0]  right_map[AlphabetSize];
  logic [7:0]  stack_mem[StackDepth];
  int          depth;
  phase_e      phase;
  int          code_cnt;
  int          run_left;
  logic [31:0] block_left;
  logic [31:0] produced;
  logic        ended;
  logic [2:0]  err_code;
  logic [30:0] size_reg;
  logic [7:0]  emit_byte;
  logic        emit_flag;

  out_word_t   expected_q[$];
  int          fails;
  bit          end_seen;

  assign fail_count_o = fails;

  function automatic void latch_error(logic [2:0] code);
    phase    = PhErr;
    err_code = code;
  endfunction

  function automatic void open_block();
    foreach (left_set[i]) left_set[i] = 1'b0;
    code_cnt = 0;
    run_left = 0;
    phase    = PhCtrl;
  endfunction

  function automatic void close_block();
    if (ended) begin
      if (produced == {1'b0, size_reg}) phase = PhDone;
      else latch_error(StSize);
    end else begin
      open_block();
    end
  endfunction

  // literal goes out, pair pushes right then left
  function automatic void resolve(logic [7:0] sym);
    logic [7:0] lf;
    lf = left_set[sym] ? left_map[sym] : sym;
    if (lf == sym) begin
      if (produced >= {1'b0, size_reg}) begin
        latch_error(StOverflow);
        return;
      end
      emit_byte = sym;
      emit_flag = 1'b1;
      produced  = produced + 1;
    end else begin
      if (depth > StackDepth - 2) begin
        latch_error(StStack);
        return;
      end
      stack_mem[depth]     = right_map[sym];
      stack_mem[depth + 1] = lf;
      depth = depth + 2;
    end
  endfunction

  function automatic void settle_data();
    if (phase == PhErr || depth != 0) return;
    if (block_left == 0) close_block();
    else if (ended) latch_error(StFormat);
  endfunction

  function automatic void next_entry();
    code_cnt++;
    if (run_left == 0) begin
      phase = (code_cnt == AlphabetSize) ? PhLen0 : PhCtrl;
    end else begin
      run_left--;
      if (code_cnt >= AlphabetSize) latch_error(StFormat);
      else phase = PhLeft;
    end
  endfunction

  function automatic void table_byte(logic [7:0] b);
    logic [7:0] c;
    int         run;
    c = code_cnt[7:0];
    case (phase)
      PhCtrl: begin
        run = int'(b);
        if (b > 8'h7f) begin
          code_cnt += int'(b) - 127;
          run = 0;
        end
        if (code_cnt == AlphabetSize) phase = PhLen0;
        else if (code_cnt > AlphabetSize) latch_error(StFormat);
        else begin
          run_left = run;
          phase    = PhLeft;
        end
      end
      PhLeft: begin
        left_map[c] = b;
        left_set[c] = 1'b1;
        if (b != c) phase = PhRight;
        else next_entry();
      end
      PhRight: begin
        right_map[c] = b;
        next_entry();
      end
      PhLen0: begin
        block_left = {24'd0, b};
        phase = PhLen1;
      end
      PhLen1: begin
        block_left[15:8] = b;
        phase = PhLen2;
      end
      PhLen2: begin
        block_left[23:16] = b;
        phase = PhLen3;
      end
      default: begin
        block_left[31:24] = b;
        phase = PhData;
        if (block_left == 0) close_block();
      end
    endcase
    if (ended && phase != PhDone && phase != PhErr) latch_error(StFormat);
  endfunction

  function automatic out_word_t decode_word(in_word_t w);
    out_word_t r;
    logic      bad_req;
    bad_req   = 1'b0;
    emit_byte = '0;
    emit_flag = 1'b0;
    if (phase != PhDone && phase != PhErr) begin
      if (w.req_type == ReqPush) begin
        if (phase == PhData && depth != 0) begin
          bad_req = 1'b1;
        end else begin
          ended = w.last_byte;
          if (phase == PhData) begin
            block_left = block_left - 1;
            resolve(w.data_byte);
            settle_data();
          end else begin
            table_byte(w.data_byte);
          end
        end
      end else if (depth == 0) begin
        bad_req = 1'b1;
      end else begin
        depth--;
        resolve(stack_mem[depth]);
        settle_data();
      end
    end
    r.out_byte  = emit_byte;
    r.out_valid = emit_flag;
    if (bad_req) r.status = StProtocol;
    else if (phase == PhErr) r.status = err_code;
    else if (phase == PhDone) r.status = StDone;
    else if (depth != 0) r.status = StDrain;
    else r.status = StMore;
    r.expansion_pending = (depth != 0);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    if (!rst_ni) begin
      foreach (right_map[i]) right_map[i] = '0;
      depth      = 0;
      block_left = '0;
      produced   = '0;
      ended      = 1'b0;
      err_code   = '0;
      size_reg   = '0;
      open_block();
      expected_q.delete();
      fails    = 0;
      end_seen = 1'b0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == AddrExpectedSize)
        size_reg = pwdata_i[30:0];
      if (in_valid_i && !in_stall_i) expected_q.push_back(decode_word(in_word_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          if (fails < 10) $display("unexpected result word %h", out_word_i);
          fails++;
        end else begin
          exp_w = expected_q.pop_front();
          if (exp_w != out_word_i) begin
            if (fails < 10)
              $display("mismatch: byte %h/%h valid %b/%b status %0d/%0d pending %b/%b",
                       exp_w.out_byte, out_word_i.out_byte, exp_w.out_valid,
                       out_word_i.out_valid, exp_w.status, out_word_i.status,
                       exp_w.expansion_pending, out_word_i.expansion_pending);
            fails++;
          end
        end
      end
      // words still owed at the end count as failures
      if (end_i && !end_seen) begin
        end_seen = 1'b1;
        if (expected_q.size() != 0) begin
          $display("%0d result words never arrived", expected_q.size());
          fails += expected_q.size();
        end
      end
    end
  end

endmodule

[test/tb_byte_pair_decompressor.sv]
// Testbench top for the byte-pair decompressor: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_byte_pair_decompressor
  import bpd_pkg::*;
();

  localparam int NumWords  = 1100;
  localparam int IdleLimit = 4000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        end_check;
  int          fail_count;

  // sender gap and receiver stall odds, in percent
  int          gap_pct;
  int          stall_pct;
  // bookkeeping of words sent and results taken
  int          words_sent;
  int          words_back;
  logic        last_pending;
  logic [2:0]  last_status;
  logic [31:0] bytes_out;
  int          quiet_cycles;

  byte_pair_decompressor i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  bpd_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pready_i    (pready),
    .end_i       (end_check),
    .fail_count_o(fail_count)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver side: random stall per cycle
  always @(posedge clk_i) out_stall <= ($urandom_range(99) < stall_pct);

  // result tracking used to steer the stimulus (pending flag, status, byte count)
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      words_back   <= 0;
      last_pending <= 1'b0;
      last_status  <= StMore;
      bytes_out    <= '0;
    end else if (out_valid && !out_stall) begin
      words_back   <= words_back + 1;
      last_pending <= out_word.expansion_pending;
      last_status  <= out_word.status;
      bytes_out    <= bytes_out + 32'(out_word.out_valid);
    end
  end

  // watchdog: cycles in which nothing moves on any port
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IdleLimit) begin
      $display("byte_pair_decompressor verification failed");
      $finish;
    end
  end

  // one word through the input channel, with random gaps ahead of it
  task automatic send_word(logic req, logic [7:0] b, logic last);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < gap_pct) @(posedge clk_i);
    end
    in_valid          <= 1'b1;
    in_word.req_type  <= req;
    in_word.data_byte <= b;
    in_word.last_byte <= last;
    do @(posedge clk_i); while (in_stall);
    words_sent++;
  endtask

  // drop valid and wait until every result word has been taken
  task automatic wait_results();
    in_valid <= 1'b0;
    while (words_back != words_sent) @(posedge clk_i);
  endtask

  // register write, only while nothing is in flight
  task automatic write_size(logic [30:0] val);
    wait_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrExpectedSize;
    pwdata  <= {1'b0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // one packed symbol, then drain its expansion; protocol noise now and then
  task automatic push_symbol(logic [7:0] sym);
    if ($urandom_range(15) == 0) send_word(ReqDrain, 8'($urandom_range(255)), 1'b0);
    send_word(ReqPush, sym, 1'b0);
    wait_results();
    while (last_pending && last_status == StDrain) begin
      if ($urandom_range(15) == 0) send_word(ReqPush, 8'($urandom_range(255)), 1'b0);
      send_word(ReqDrain, 8'($urandom_range(255)), 1'b0);
      wait_results();
    end
  endtask

  // one table entry for a code: identity, or a pair of lower codes
  task automatic send_entry(int code);
    if (code > 0 && $urandom_range(1) == 1) begin
      send_word(ReqPush, 8'($urandom_range(code - 1)), 1'b0);
      send_word(ReqPush, 8'($urandom_range(code - 1)), 1'b0);
    end else begin
      send_word(ReqPush, 8'(code), 1'b0);
    end
  endtask

  // random block: short pair table mostly skips, pairs point to lower codes
  task automatic random_block();
    int cc;
    int k;
    int len;
    cc = 0;
    while (cc < AlphabetSize) begin
      if ($urandom_range(2) != 0) begin
        // a skip is followed by one entry at the code it lands on
        k = $urandom_range(1, (AlphabetSize - cc < 128) ? AlphabetSize - cc : 128);
        send_word(ReqPush, 8'(127 + k), 1'b0);
        cc += k;
        if (cc < AlphabetSize) begin
          send_entry(cc);
          cc++;
        end
      end else begin
        k = $urandom_range(1, (AlphabetSize - cc < 4) ? AlphabetSize - cc : 4);
        send_word(ReqPush, 8'(k - 1), 1'b0);
        repeat (k) begin
          send_entry(cc);
          cc++;
        end
      end
    end
    len = $urandom_range(12);
    send_word(ReqPush, 8'(len), 1'b0);
    repeat (3) send_word(ReqPush, 8'h00, 1'b0);
    repeat (len) push_symbol(8'($urandom_range(255)));
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_word      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    end_check    = 1'b0;
    gap_pct      = 0;
    stall_pct    = 0;
    words_sent   = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_size(31'd0);
    write_size(31'h7fff_ffff);

    // directed block: run of two (literal 0, pair 1), max skip, run up to code 255
    send_word(ReqDrain, 8'h00, 1'b0);          // drain with empty stack
    send_word(ReqPush, 8'h01, 1'b0);
    send_word(ReqPush, 8'h00, 1'b0);
    send_word(ReqPush, 8'h00, 1'b0);
    send_word(ReqPush, 8'h00, 1'b0);
    send_word(ReqPush, 8'hff, 1'b0);           // max skip to code 130
    send_word(ReqPush, 8'h82, 1'b0);           // 130 identity
    send_word(ReqPush, 8'hf8, 1'b0);           // skip to code 252
    send_word(ReqPush, 8'hfc, 1'b0);           // 252 identity
    send_word(ReqPush, 8'h02, 1'b0);           // run of three
    send_word(ReqPush, 8'hfc, 1'b0);           // 253 -> (252, 1)
    send_word(ReqPush, 8'h01, 1'b0);
    send_word(ReqPush, 8'hfd, 1'b0);           // 254 -> (253, 255)
    send_word(ReqPush, 8'hff, 1'b0);
    send_word(ReqPush, 8'hff, 1'b0);           // 255 identity
    send_word(ReqPush, 8'h06, 1'b0);
    repeat (3) send_word(ReqPush, 8'h00, 1'b0);
    push_symbol(8'h00);
    push_symbol(8'h01);
    push_symbol(8'hfe);
    push_symbol(8'hfd);
    push_symbol(8'hff);
    push_symbol(8'h80);

    // random part in four idling phases, size register rewritten between them
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 50; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 50; end
        default: begin gap_pct = 38; stall_pct = 38; end
      endcase
      write_size(31'($urandom_range(32'h7fff_ffff, 32'h4000_0000)));
      while (words_sent < (ph + 1) * NumWords / 4) random_block();
    end

    // closing block: size set to the exact output count, empty data, end of stream
    write_size(bytes_out[30:0]);
    send_word(ReqPush, 8'hff, 1'b0);           // skip to code 128
    send_word(ReqPush, 8'h80, 1'b0);           // 128 identity
    send_word(ReqPush, 8'hfe, 1'b0);           // skip to the end of the table
    repeat (3) send_word(ReqPush, 8'h00, 1'b0);
    send_word(ReqPush, 8'h00, 1'b1);
    // after termination every word just repeats the final status
    repeat (6) send_word(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));

    wait_results();
    repeat (10) @(posedge clk_i);
    end_check <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("byte_pair_decompressor verification clean");
    end else begin
      $display("byte_pair_decompressor verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/bpd_pkg.sv
hdl/bpd_ram.sv
hdl/byte_pair_decompressor.sv
test/bpd_checker.sv
test/tb_byte_pair_decompressor.sv
